/* hdl/mfc_pkg.sv */
// ----------------------------------------------------------------------------
// mfc_pkg: shared constants and types of the Modbus reply frame checker
// Holds the CRC constants, header codes, verdict codes and the verdict record.
// ----------------------------------------------------------------------------
package mfc_pkg;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [7:0]  MIN_FRAME_LEN = 8'd7;
	localparam logic [7:0]  COUNT_OFFSET  = 8'd5;
	localparam logic [7:0]  LEN_MAX       = 8'hFF;
	localparam logic [7:0]  ADDR_RESET    = 8'hFE;
	localparam logic [7:0]  FUNC_RD_HOLD  = 8'h03;
	localparam logic [7:0]  FUNC_RD_INPUT = 8'h04;

	// Byte positions within the frame
	localparam logic [7:0]  POS_ADDR      = 8'd0;
	localparam logic [7:0]  POS_FUNC      = 8'd1;
	localparam logic [7:0]  POS_COUNT     = 8'd2;
	localparam logic [7:0]  POS_DATA_OUT  = 8'd5;

	// Verdict codes
	localparam logic [2:0]  ERR_OK        = 3'd0;
	localparam logic [2:0]  ERR_LEN       = 3'd1;
	localparam logic [2:0]  ERR_SHORT     = 3'd2;
	localparam logic [2:0]  ERR_CRC       = 3'd3;
	localparam logic [2:0]  ERR_HEADER    = 3'd4;

	typedef struct packed {
		logic        frame_ok;
		logic [2:0]  error_code;
		logic [31:0] payload_word;
		logic [7:0]  received_len;
	} verdict_t;

endpackage

/* hdl/mfc_if.sv */
// ----------------------------------------------------------------------------
// mfc_if: valid/ready channels of the Modbus reply frame checker
// Receive byte channel, verdict channel and configuration write channel.
// ----------------------------------------------------------------------------
interface mfc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       last_byte;
	logic [7:0] expected_len;

	modport source (output valid, output rx_byte, output last_byte, output expected_len,
		input ready);
	modport sink (input valid, input rx_byte, input last_byte, input expected_len,
		output ready);
endinterface

interface mfc_res_if;
	logic        valid;
	logic        ready;
	logic        frame_ok;
	logic [2:0]  error_code;
	logic [31:0] payload_word;
	logic [7:0]  received_len;

	modport source (output valid, output frame_ok, output error_code, output payload_word,
		output received_len, input ready);
	modport sink (input valid, input frame_ok, input error_code, input payload_word,
		input received_len, output ready);
endinterface

interface mfc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] slave_address;

	modport source (output valid, output slave_address, input ready);
	modport sink (input valid, input slave_address, output ready);
endinterface

/* hdl/mfc_crc_byte.sv */
// ----------------------------------------------------------------------------
// mfc_crc_byte: one-byte Modbus CRC-16 update
// Reflected polynomial 0xA001, eight bit steps unrolled.
// ----------------------------------------------------------------------------
module mfc_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ mfc_pkg::CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		crc_out = crc;
	end

endmodule

/* hdl/mfc_frame_track.sv */
// ----------------------------------------------------------------------------
// mfc_frame_track: per-frame state and verdict of the reply checker
// Tracks CRC, length, header and data bytes; forms the verdict on the last byte.
// ----------------------------------------------------------------------------
module mfc_frame_track (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        rx_byte,
	input  logic              last_byte,
	input  logic [7:0]        expected_len,
	input  logic [7:0]        slave_address,
	output mfc_pkg::verdict_t verdict
);

	logic [15:0] crc_q;
	logic [7:0]  bytes_seen_q;
	logic [7:0]  count_field_q;
	logic        header_good_q;
	logic [31:0] data_acc_q;
	logic [15:0] tail_q;

	logic [15:0] crc_next;
	logic [7:0]  len_next;
	logic [7:0]  count_next;
	logic        header_next;
	logic [31:0] acc_next;
	logic [15:0] tail_next;
	logic [2:0]  err;

	mfc_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (rx_byte),
		.crc_out (crc_next)
	);

	always_comb begin
		header_next = header_good_q;
		if (bytes_seen_q == mfc_pkg::POS_ADDR && rx_byte != slave_address) begin
			header_next = 1'b0;
		end
		if (bytes_seen_q == mfc_pkg::POS_FUNC && rx_byte != mfc_pkg::FUNC_RD_HOLD
				&& rx_byte != mfc_pkg::FUNC_RD_INPUT) begin
			header_next = 1'b0;
		end
		count_next = (bytes_seen_q == mfc_pkg::POS_COUNT) ? rx_byte : count_field_q;
		// Data lags two bytes behind so the CRC bytes never enter the word
		acc_next   = (bytes_seen_q >= mfc_pkg::POS_DATA_OUT) ?
			{data_acc_q[23:0], tail_q[15:8]} : data_acc_q;
		tail_next  = {tail_q[7:0], rx_byte};
		len_next   = (bytes_seen_q == mfc_pkg::LEN_MAX) ? mfc_pkg::LEN_MAX :
			bytes_seen_q + 8'd1;
	end

	always_comb begin
		priority if (len_next != expected_len) begin
			err = mfc_pkg::ERR_LEN;
		end else if (len_next < mfc_pkg::MIN_FRAME_LEN) begin
			err = mfc_pkg::ERR_SHORT;
		end else if (crc_next != 16'h0000) begin
			err = mfc_pkg::ERR_CRC;
		end else if (!header_next || count_next != len_next - mfc_pkg::COUNT_OFFSET) begin
			err = mfc_pkg::ERR_HEADER;
		end else begin
			err = mfc_pkg::ERR_OK;
		end
		verdict.frame_ok     = (err == mfc_pkg::ERR_OK);
		verdict.error_code   = err;
		verdict.payload_word = (err == mfc_pkg::ERR_OK) ? acc_next : 32'h0;
		verdict.received_len = len_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q         <= mfc_pkg::CRC_INIT;
			bytes_seen_q  <= 8'h00;
			count_field_q <= 8'h00;
			header_good_q <= 1'b1;
			data_acc_q    <= 32'h0;
			tail_q        <= 16'h0;
		end else if (advance) begin
			if (last_byte) begin
				// Clear for the next frame
				crc_q         <= mfc_pkg::CRC_INIT;
				bytes_seen_q  <= 8'h00;
				count_field_q <= 8'h00;
				header_good_q <= 1'b1;
				data_acc_q    <= 32'h0;
				tail_q        <= 16'h0;
			end else begin
				crc_q         <= crc_next;
				bytes_seen_q  <= len_next;
				count_field_q <= count_next;
				header_good_q <= header_next;
				data_acc_q    <= acc_next;
				tail_q        <= tail_next;
			end
		end
	end

endmodule

/* hdl/modbus_response_frame_check.sv */
// ----------------------------------------------------------------------------
// modbus_response_frame_check: Modbus RTU read-register reply checker
// Checks a received reply byte by byte and reports one verdict per frame.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one beat per received byte; last_byte marks the final byte and
//         expected_len is sampled with it.
//   res : one beat per frame, after the last byte: frame_ok, error_code,
//         payload_word (data bytes packed big-endian) and received_len.
//   cfg : write beat carrying slave_address; always ready, write only while
//         no frame is in progress.
// Throughput: one byte per cycle, unless a last byte stalls (see Stall). Each
//   byte sits in the input register, where the unrolled byte CRC update and the
//   frame state logic consume it.
// Verdict path: the last byte passes the input register, then the result register offers the verdict.
// Reset: frame state clears (CRC 0xFFFF, count zero), slave_address returns
//   to 0xFE, both channels come up empty.
// Stall: while a verdict waits on res, ordinary bytes keep flowing; a second
//   last byte holds in the input register and rx.ready drops until res
//   takes its beat.
// ----------------------------------------------------------------------------
module modbus_response_frame_check (
	input  logic       clk,
	input  logic       arst_n,
	mfc_rx_if.sink     rx,
	mfc_res_if.source  res,
	mfc_cfg_if.sink    cfg
);

	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	logic              last_s1;
	logic [7:0]        expected_len_s1;
	logic              advance_s1;

	logic              out_valid_q;
	mfc_pkg::verdict_t out_q;
	mfc_pkg::verdict_t verdict;

	logic [7:0]        slave_address_q;

	// Config register: always accept the write beat
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= mfc_pkg::ADDR_RESET;
		end else if (cfg.valid) begin
			slave_address_q <= cfg.slave_address;
		end
	end

	// Advance the input stage unless a verdict has nowhere to go
	assign advance_s1 = valid_s1 && (!last_s1 || !out_valid_q || res.ready);
	assign rx.ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			rx_byte_s1      <= rx.rx_byte;
			last_s1         <= rx.last_byte;
			expected_len_s1 <= rx.expected_len;
		end
	end

	mfc_frame_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance_s1),
		.rx_byte       (rx_byte_s1),
		.last_byte     (last_s1),
		.expected_len  (expected_len_s1),
		.slave_address (slave_address_q),
		.verdict       (verdict)
	);

	// Result register: load on a last byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			out_q <= verdict;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.frame_ok     = out_q.frame_ok;
	assign res.error_code   = out_q.error_code;
	assign res.payload_word = out_q.payload_word;
	assign res.received_len = out_q.received_len;

`ifndef ASSERT_OFF
	a_ok_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.frame_ok == (out_q.error_code == mfc_pkg::ERR_OK)))
		else $error("frame_ok disagrees with error_code");

	a_fail_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.frame_ok) |-> (out_q.payload_word == 32'h0))
		else $error("failed frame carries a payload");

	a_short_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.received_len < mfc_pkg::MIN_FRAME_LEN) |->
		(out_q.error_code == mfc_pkg::ERR_LEN || out_q.error_code == mfc_pkg::ERR_SHORT))
		else $error("short frame not flagged");

	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_valid_q && !res.ready) |=> (valid_s1 && last_s1))
		else $error("stalled last byte lost from input stage");
`endif

endmodule
